>>> hdl/text_console_cell_writer_macros.svh
// Assertion macros for the console cell writer.
`ifndef TEXT_CONSOLE_CELL_WRITER_MACROS_SVH
`define TEXT_CONSOLE_CELL_WRITER_MACROS_SVH

`ifndef NO_ASSERTIONS

// Consequent must hold in the same cycle as the antecedent.
`define TCW_ASSERT_SAME(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error(msg);

// Consequent must hold in the cycle after the antecedent.
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error(msg);

`else

`define TCW_ASSERT_SAME(lbl, clk, rst, ante, cons, msg)
`define TCW_ASSERT_NEXT(lbl, clk, rst, ante, cons, msg)

`endif

`endif

>>> hdl/tcw_pkg.sv
`timescale 1ns / 1ps
package tcw_pkg;

   localparam int COLUMNS = 80;
   localparam int ROWS    = 25;
   localparam int CELLS   = COLUMNS * ROWS;

   // port field widths
   localparam int FUNC_W   = 2;
   localparam int CHAR_W   = 8;
   localparam int COLOUR_W = 8;
   localparam int INDEX_W  = 11;
   localparam int CURSOR_W = 11;
   localparam int CELL_W   = CHAR_W + COLOUR_W;

   // internal widths
   localparam int ADDR_W    = $clog2(CELLS);
   localparam int CUR_W     = $clog2(CELLS + COLUMNS);
   localparam int COL_W     = $clog2(COLUMNS);
   localparam int CNT_W     = $clog2(CELLS + 1);
   localparam int IDX_CMP_W = ((INDEX_W > CNT_W) ? INDEX_W : CNT_W) + 1;

   localparam logic [FUNC_W-1:0] FUNC_PUT   = 2'd0;
   localparam logic [FUNC_W-1:0] FUNC_READ  = 2'd1;
   localparam logic [FUNC_W-1:0] FUNC_WRITE = 2'd2;

   localparam logic [CHAR_W-1:0] CODE_BS = 8'd8;
   localparam logic [CHAR_W-1:0] CODE_LF = 8'd10;
   localparam logic [CHAR_W-1:0] CODE_CR = 8'd13;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
      logic [CELL_W-1:0] data;
   } mem_wr_type;

   typedef struct packed {
      logic              en;
      logic [ADDR_W-1:0] addr;
   } mem_rd_type;

   typedef struct packed {
      logic                valid;
      logic [CHAR_W-1:0]   cell_char;
      logic [COLOUR_W-1:0] cell_colour;
      logic [CURSOR_W-1:0] cursor_cell;
      logic                scrolled;
   } rsp_type;

endpackage

>>> hdl/tcw_cell_ram.sv
`timescale 1ns / 1ps
module tcw_cell_ram (
   input  logic                        clock,
   input  tcw_pkg::mem_wr_type         wr,
   input  tcw_pkg::mem_rd_type         rd,
   output logic [tcw_pkg::CELL_W-1:0]  rd_data
);
   import tcw_pkg::*;

   logic [CELL_W-1:0] mem [CELLS];

   always_ff @(posedge clock) begin
      if (wr.en) begin
         mem[wr.addr] <= wr.data;
      end
   end

   // hold the last read word until the next read
   always_ff @(posedge clock) begin
      if (rd.en) begin
         rd_data <= mem[rd.addr];
      end
   end

endmodule

>>> hdl/tcw_seq.sv
`timescale 1ns / 1ps
module tcw_seq (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tcw_pkg::FUNC_W-1:0]    req_func,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::COLOUR_W-1:0]  req_colour,
   input  logic [tcw_pkg::INDEX_W-1:0]   req_cell_index,
   input  logic                          out_free,
   output tcw_pkg::rsp_type              rsp,
   output tcw_pkg::mem_wr_type           mem_wr,
   output tcw_pkg::mem_rd_type           mem_rd,
   input  logic [tcw_pkg::CELL_W-1:0]    rd_data
);
   import tcw_pkg::*;

   localparam logic [1:0] ST_CLEAR  = 2'd0;
   localparam logic [1:0] ST_IDLE   = 2'd1;
   localparam logic [1:0] ST_EXEC   = 2'd2;
   localparam logic [1:0] ST_SCROLL = 2'd3;

   logic [1:0]          state_ff, state_in;
   logic [CNT_W-1:0]    cnt_ff, cnt_in;
   logic [CUR_W-1:0]    cur_ff, cur_in;
   logic [COL_W-1:0]    col_ff, col_in;
   logic [FUNC_W-1:0]   func_ff, func_in;
   logic [CHAR_W-1:0]   char_ff, char_in;
   logic [COLOUR_W-1:0] colour_ff, colour_in;
   logic [ADDR_W-1:0]   idx_ff, idx_in;
   logic                idx_ok_ff, idx_ok_in;

   logic                req_idx_ok;
   logic [CUR_W-1:0]    bs_addr;
   logic [CUR_W-1:0]    cur_sum;
   logic [COL_W-1:0]    col_nx;
   logic                scroll;

   assign req_stall  = (state_ff != ST_IDLE);
   assign req_idx_ok = IDX_CMP_W'(req_cell_index) < IDX_CMP_W'(CELLS);
   // backspace stops at the top left cell
   assign bs_addr    = (cur_ff == '0) ? '0 : cur_ff - CUR_W'(1);

   always_comb begin
      state_in  = state_ff;
      cnt_in    = cnt_ff;
      cur_in    = cur_ff;
      col_in    = col_ff;
      func_in   = func_ff;
      char_in   = char_ff;
      colour_in = colour_ff;
      idx_in    = idx_ff;
      idx_ok_in = idx_ok_ff;
      cur_sum   = cur_ff;
      col_nx    = col_ff;
      scroll    = 1'b0;
      mem_wr    = '0;
      mem_rd    = '0;
      rsp       = '0;

      unique case (state_ff)
         ST_CLEAR: begin
            mem_wr.en   = 1'b1;
            mem_wr.addr = ADDR_W'(cnt_ff);
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CELLS - 1)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end

         ST_IDLE: begin
            if (req_valid) begin
               func_in   = req_func;
               char_in   = req_char_code;
               colour_in = req_colour;
               idx_in    = ADDR_W'(req_cell_index);
               idx_ok_in = req_idx_ok;
               state_in  = ST_EXEC;
               mem_rd.en = 1'b1;
               if (req_func == FUNC_PUT) begin
                  mem_rd.addr = (req_char_code == CODE_BS) ? ADDR_W'(bs_addr)
                                                           : ADDR_W'(cur_ff);
               end else begin
                  mem_rd.addr = req_idx_ok ? ADDR_W'(req_cell_index) : '0;
               end
            end
         end

         ST_EXEC: begin
            if (out_free) begin
               state_in = ST_IDLE;
               if (func_ff == FUNC_PUT) begin
                  unique case (char_ff)
                     CODE_LF: begin
                        cur_sum = cur_ff + CUR_W'(COLUMNS);
                     end
                     CODE_CR: begin
                        cur_sum = cur_ff - CUR_W'(col_ff);
                        col_nx  = '0;
                     end
                     CODE_BS: begin
                        cur_sum     = bs_addr;
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = ADDR_W'(bs_addr);
                        mem_wr.data = {rd_data[CELL_W-1:CHAR_W], CHAR_W'(0)};
                        if (col_ff != '0) begin
                           col_nx = col_ff - COL_W'(1);
                        end else if (cur_ff != '0) begin
                           col_nx = COL_W'(COLUMNS - 1);
                        end
                     end
                     default: begin
                        cur_sum     = cur_ff + CUR_W'(1);
                        mem_wr.en   = 1'b1;
                        mem_wr.addr = ADDR_W'(cur_ff);
                        mem_wr.data = {colour_ff, char_ff};
                        col_nx      = (col_ff == COL_W'(COLUMNS - 1)) ? '0
                                                                      : col_ff + COL_W'(1);
                     end
                  endcase
                  col_in = col_nx;
                  if (cur_sum >= CUR_W'(CELLS)) begin
                     scroll   = 1'b1;
                     cur_in   = cur_sum - CUR_W'(COLUMNS);
                     cnt_in   = '0;
                     state_in = ST_SCROLL;
                  end else begin
                     cur_in = cur_sum;
                  end
               end else if (func_ff == FUNC_WRITE && idx_ok_ff) begin
                  mem_wr.en   = 1'b1;
                  mem_wr.addr = idx_ff;
                  mem_wr.data = {colour_ff, char_ff};
               end

               rsp.valid       = 1'b1;
               rsp.cursor_cell = CURSOR_W'(cur_in);
               rsp.scrolled    = scroll;
               if (func_ff == FUNC_READ && idx_ok_ff) begin
                  rsp.cell_char   = rd_data[CHAR_W-1:0];
                  rsp.cell_colour = rd_data[CELL_W-1:CHAR_W];
               end
            end
         end

         ST_SCROLL: begin
            // read one row ahead, write the word read last cycle one cell behind
            mem_rd.en   = cnt_ff < CNT_W'(CELLS - COLUMNS);
            mem_rd.addr = ADDR_W'(cnt_ff + CNT_W'(COLUMNS));
            mem_wr.en   = (cnt_ff != '0);
            mem_wr.addr = ADDR_W'(cnt_ff - CNT_W'(1));
            mem_wr.data = (cnt_ff <= CNT_W'(CELLS - COLUMNS)) ? rd_data : '0;
            cnt_in      = cnt_ff + CNT_W'(1);
            if (cnt_ff == CNT_W'(CELLS)) begin
               cnt_in   = '0;
               state_in = ST_IDLE;
            end
         end

         default: begin
            state_in = ST_CLEAR;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff <= ST_CLEAR;
         cnt_ff   <= '0;
         cur_ff   <= '0;
         col_ff   <= '0;
      end else begin
         state_ff <= state_in;
         cnt_ff   <= cnt_in;
         cur_ff   <= cur_in;
         col_ff   <= col_in;
      end
   end

   always_ff @(posedge clock) begin
      func_ff   <= func_in;
      char_ff   <= char_in;
      colour_ff <= colour_in;
      idx_ff    <= idx_in;
      idx_ok_ff <= idx_ok_in;
   end

endmodule

>>> hdl/text_console_cell_writer.sv
// Flow: an accepted word waits in the EXEC state until the output register is free, then
// its result is loaded there. req_stall holds off the next word until then and, after a put
// that scrolls, while the store moves up a row via the memory's read and write ports.
// Reset: synchronous, active high; afterwards the store is cleared one cell per cycle,
// all CELLS of them, with req_stall high, and the cursor sits at the top left cell.
`timescale 1ns / 1ps
`include "text_console_cell_writer_macros.svh"
module text_console_cell_writer (
   input  logic                          clock,
   input  logic                          reset,
   input  logic                          req_valid,
   output logic                          req_stall,
   input  logic [tcw_pkg::FUNC_W-1:0]    req_func,
   input  logic [tcw_pkg::CHAR_W-1:0]    req_char_code,
   input  logic [tcw_pkg::COLOUR_W-1:0]  req_colour,
   input  logic [tcw_pkg::INDEX_W-1:0]   req_cell_index,
   output logic                          rsp_valid,
   input  logic                          rsp_stall,
   output logic [tcw_pkg::CHAR_W-1:0]    rsp_cell_char,
   output logic [tcw_pkg::COLOUR_W-1:0]  rsp_cell_colour,
   output logic [tcw_pkg::CURSOR_W-1:0]  rsp_cursor_cell,
   output logic                          rsp_scrolled
);
   import tcw_pkg::*;

   rsp_type             seq_rsp;
   mem_wr_type          mem_wr;
   mem_rd_type          mem_rd;
   logic [CELL_W-1:0]   rd_data;
   logic                out_free;

   logic                rsp_valid_ff, rsp_valid_in;
   logic [CHAR_W-1:0]   char_ff;
   logic [COLOUR_W-1:0] colour_ff;
   logic [CURSOR_W-1:0] cursor_ff;
   logic                scrolled_ff;

   tcw_seq u_seq (
      .clock          (clock),
      .reset          (reset),
      .req_valid      (req_valid),
      .req_stall      (req_stall),
      .req_func       (req_func),
      .req_char_code  (req_char_code),
      .req_colour     (req_colour),
      .req_cell_index (req_cell_index),
      .out_free       (out_free),
      .rsp            (seq_rsp),
      .mem_wr         (mem_wr),
      .mem_rd         (mem_rd),
      .rd_data        (rd_data)
   );

   tcw_cell_ram u_ram (
      .clock   (clock),
      .wr      (mem_wr),
      .rd      (mem_rd),
      .rd_data (rd_data)
   );

   // output register frees when empty or when its word leaves this cycle
   assign out_free     = !rsp_valid_ff || !rsp_stall;
   assign rsp_valid_in = seq_rsp.valid || (rsp_valid_ff && rsp_stall);

   always_ff @(posedge clock) begin
      if (reset) begin
         rsp_valid_ff <= 1'b0;
      end else begin
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   always_ff @(posedge clock) begin
      if (seq_rsp.valid) begin
         char_ff     <= seq_rsp.cell_char;
         colour_ff   <= seq_rsp.cell_colour;
         cursor_ff   <= seq_rsp.cursor_cell;
         scrolled_ff <= seq_rsp.scrolled;
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_cell_char   = char_ff;
   assign rsp_cell_colour = colour_ff;
   assign rsp_cursor_cell = cursor_ff;
   assign rsp_scrolled    = scrolled_ff;

   `TCW_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && !req_stall, req_stall, "accepted word did not hold off the next one")
   `TCW_ASSERT_SAME(a_cursor_in_range, clock, reset, rsp_valid_ff, rsp_cursor_cell < CELLS, "cursor beyond the last cell")
   `TCW_ASSERT_NEXT(a_scroll_blocks_input, clock, reset, seq_rsp.valid && seq_rsp.scrolled, req_stall, "input taken while the store scrolls")
   `TCW_ASSERT_SAME(a_no_result_overrun, clock, reset, rsp_valid_ff && rsp_stall, !seq_rsp.valid, "result loaded over a stalled word")

endmodule

>>> verif/testbench.sv
`timescale 1ns / 1ps
module testbench;
   import tcw_pkg::*;

   localparam logic [FUNC_W-1:0] FUNC_UNUSED = 2'd3;
   localparam int WORD_COUNT      = 1100;
   localparam int LF_SCROLL_LIMIT = 100;
   localparam int HOLD_OFF_CYCLES = 400;
   localparam int IDLE_PCT        = 17;

   typedef struct packed {
      logic [CHAR_W-1:0]   cell_char;
      logic [COLOUR_W-1:0] cell_colour;
      logic [CURSOR_W-1:0] cursor_cell;
      logic                scrolled;
   } console_reply_type;

   class console_scoreboard;
      bit [CELL_W-1:0] cells [CELLS];
      int              cursor_pos;
      console_reply_type console_replies [$];
      int mismatches, checked, scrolls, puts, reads, writes, unused;

      function void apply_word(logic [FUNC_W-1:0] func, logic [CHAR_W-1:0] ch,
                               logic [COLOUR_W-1:0] colour, logic [INDEX_W-1:0] idx);
         console_reply_type reply;
         reply = '0;
         case (func)
            FUNC_PUT: begin
               puts++;
               if (ch == CODE_LF) begin
                  cursor_pos += COLUMNS;
               end else if (ch == CODE_CR) begin
                  cursor_pos -= cursor_pos % COLUMNS;
               end else if (ch == CODE_BS) begin
                  if (cursor_pos > 0) cursor_pos--;
                  cells[cursor_pos][CHAR_W-1:0] = '0;
               end else begin
                  cells[cursor_pos] = {colour, ch};
                  cursor_pos++;
               end
               if (cursor_pos >= CELLS) begin
                  // shift every row up one, blank the last
                  for (int i = 0; i < CELLS - COLUMNS; i++) cells[i] = cells[i + COLUMNS];
                  for (int i = CELLS - COLUMNS; i < CELLS; i++) cells[i] = '0;
                  cursor_pos -= COLUMNS;
                  reply.scrolled = 1'b1;
                  scrolls++;
               end
            end
            FUNC_READ: begin
               reads++;
               if (idx < CELLS) {reply.cell_colour, reply.cell_char} = cells[idx];
            end
            FUNC_WRITE: begin
               writes++;
               if (idx < CELLS) cells[idx] = {colour, ch};
            end
            default: unused++;
         endcase
         reply.cursor_cell = cursor_pos[CURSOR_W-1:0];
         console_replies.push_back(reply);
      endfunction

      function void check_result(logic [CHAR_W-1:0] ch, logic [COLOUR_W-1:0] colour,
                                 logic [CURSOR_W-1:0] cursor, logic scrolled);
         console_reply_type want;
         if (console_replies.size() == 0) begin
            mismatches++;
            if (mismatches <= 10)
               $display("unexpected word: char %h colour %h cursor %0d scrolled %b",
                        ch, colour, cursor, scrolled);
            return;
         end
         want = console_replies.pop_front();
         checked++;
         if (ch !== want.cell_char || colour !== want.cell_colour ||
             cursor !== want.cursor_cell || scrolled !== want.scrolled) begin
            mismatches++;
            if (mismatches <= 10)
               $display("mismatch on word %0d: expected char %h colour %h cursor %0d scrolled %b,%s",
                        checked, want.cell_char, want.cell_colour, want.cursor_cell,
                        want.scrolled, $sformatf(" got char %h colour %h cursor %0d scrolled %b",
                        ch, colour, cursor, scrolled));
         end
      endfunction

      function int pending();
         return console_replies.size();
      endfunction
   endclass

   logic                clock = 1'b0;
   logic                reset = 1'b1;
   logic                req_valid = 1'b0;
   logic                req_stall;
   logic [FUNC_W-1:0]   req_func = FUNC_PUT;
   logic [CHAR_W-1:0]   req_char_code = '0;
   logic [COLOUR_W-1:0] req_colour = '0;
   logic [INDEX_W-1:0]  req_cell_index = '0;
   logic                rsp_valid;
   logic                rsp_stall = 1'b0;
   logic [CHAR_W-1:0]   rsp_cell_char;
   logic [COLOUR_W-1:0] rsp_cell_colour;
   logic [CURSOR_W-1:0] rsp_cursor_cell;
   logic                rsp_scrolled;

   console_scoreboard sb = new;
   int sent = 0;
   int req_idle_pct = IDLE_PCT;
   int rsp_idle_pct = IDLE_PCT;
   int hold_off_requests = 0;

   text_console_cell_writer uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_stall(req_stall), .req_func(req_func),
      .req_char_code(req_char_code), .req_colour(req_colour),
      .req_cell_index(req_cell_index),
      .rsp_valid(rsp_valid), .rsp_stall(rsp_stall), .rsp_cell_char(rsp_cell_char),
      .rsp_cell_colour(rsp_cell_colour), .rsp_cursor_cell(rsp_cursor_cell),
      .rsp_scrolled(rsp_scrolled)
   );

   always #2 clock = ~clock;

   task automatic send_word(input logic [FUNC_W-1:0] func, input logic [CHAR_W-1:0] ch,
                            input logic [COLOUR_W-1:0] colour,
                            input logic [INDEX_W-1:0] idx);
      logic [CHAR_W-1:0] code;
      code = ch;
      // each line feed on the last row costs a full scroll; cap them
      if (func == FUNC_PUT && ch == CODE_LF && sb.scrolls >= LF_SCROLL_LIMIT) code = CODE_CR;
      req_valid      <= 1'b1;
      req_func       <= func;
      req_char_code  <= code;
      req_colour     <= colour;
      req_cell_index <= idx;
      @(posedge clock);
      while (req_stall) @(posedge clock);
      sb.apply_word(func, code, colour, idx);
      sent++;
      if ($urandom_range(99) < req_idle_pct) begin
         req_valid <= 1'b0;
         repeat ($urandom_range(1, 4)) @(posedge clock);
      end
   endtask

   task automatic put_char(input logic [CHAR_W-1:0] ch, input logic [COLOUR_W-1:0] colour);
      send_word(FUNC_PUT, ch, colour, INDEX_W'($urandom_range(0, 2047)));
   endtask

   task automatic read_cell(input int idx);
      send_word(FUNC_READ, CHAR_W'($urandom_range(0, 255)), COLOUR_W'($urandom_range(0, 255)),
                INDEX_W'(idx));
   endtask

   initial begin : driver
      int kind, n, idx, r;
      logic [COLOUR_W-1:0] run_colour;
      repeat (8) @(posedge clock);
      reset <= 1'b0;

      // reads and writes at and past the edges of the store, then an unused selector
      send_word(FUNC_READ, 8'h00, 8'h00, 11'd0);
      send_word(FUNC_READ, 8'hFF, 8'hFF, 11'd1999);
      send_word(FUNC_READ, 8'h00, 8'h00, 11'd2000);
      send_word(FUNC_READ, 8'h00, 8'h00, 11'd2047);
      send_word(FUNC_WRITE, 8'hFF, 8'hFF, 11'd2047);
      send_word(FUNC_WRITE, 8'h11, 8'h22, 11'd2000);
      send_word(FUNC_WRITE, 8'h5A, 8'hA5, 11'd1999);
      send_word(FUNC_READ, 8'h00, 8'h00, 11'd1999);
      send_word(FUNC_UNUSED, 8'hFF, 8'hFF, 11'h7FF);
      // text, backspace down to and at the top left cell, then line feed, carriage return and cell 80
      put_char(8'hFF, 8'hFF);
      put_char(8'h00, 8'h00);
      put_char(CODE_BS, 8'h00);
      put_char(CODE_BS, 8'h00);
      put_char(CODE_BS, 8'h00);
      send_word(FUNC_READ, 8'h00, 8'h00, 11'd0);
      put_char(8'h41, 8'h1F);
      put_char(CODE_LF, 8'h00);
      put_char(CODE_CR, 8'h00);
      send_word(FUNC_WRITE, 8'h42, 8'h70, 11'd80);
      send_word(FUNC_READ, 8'h00, 8'h00, 11'd80);

      // line feeds down the screen until the store scrolls
      repeat (25) put_char(CODE_LF, COLOUR_W'($urandom_range(0, 255)));
      read_cell(0);
      read_cell(1999);

      while (sent < WORD_COUNT) begin
         // quiet window on both sides, then one long receiver hold-off
         req_idle_pct = (sent >= 400 && sent < 600) ? 0 : IDLE_PCT;
         rsp_idle_pct = req_idle_pct;
         if (sent >= 700 && hold_off_requests == 0) hold_off_requests++;
         kind = $urandom_range(99);
         if (kind < 35) begin
            n = $urandom_range(5, 60);
            run_colour = COLOUR_W'($urandom_range(0, 255));
            repeat (n) begin
               r = $urandom_range(99);
               if (r < 6) put_char(CODE_CR, run_colour);
               else if (r < 10) put_char(CODE_LF, run_colour);
               else if (r < 14) put_char(CODE_BS, run_colour);
               else if (r < 24) put_char(CHAR_W'($urandom_range(0, 255)),
                                         COLOUR_W'($urandom_range(0, 255)));
               else put_char(CHAR_W'($urandom_range(32, 126)), run_colour);
            end
         end else if (kind < 47) begin
            repeat ($urandom_range(1, 30)) put_char(CODE_LF, COLOUR_W'($urandom_range(0, 255)));
         end else if (kind < 56) begin
            repeat ($urandom_range(1, 20)) put_char(CODE_BS, COLOUR_W'($urandom_range(0, 255)));
         end else if (kind < 71) begin
            idx = ($urandom_range(9) == 0) ? $urandom_range(0, 2047) : $urandom_range(0, 1999);
            send_word(FUNC_WRITE, CHAR_W'($urandom_range(0, 255)),
                      COLOUR_W'($urandom_range(0, 255)), INDEX_W'(idx));
            read_cell(idx);
         end else if (kind < 87) begin
            repeat ($urandom_range(1, 10)) begin
               // mostly look just behind the cursor, where text has landed
               if ($urandom_range(3) == 0) begin
                  idx = $urandom_range(0, 2047);
               end else begin
                  idx = sb.cursor_pos - int'($urandom_range(0, 80));
                  if (idx < 0) idx = 0;
               end
               read_cell(idx);
            end
         end else begin
            repeat ($urandom_range(1, 10))
               send_word(FUNC_W'($urandom_range(0, 3)), CHAR_W'($urandom_range(0, 255)),
                         COLOUR_W'($urandom_range(0, 255)), INDEX_W'($urandom_range(0, 2047)));
         end
      end

      req_valid <= 1'b0;
      while (sb.pending() != 0) @(posedge clock);
      repeat (20) @(posedge clock);
      $display("Sent %0d words: %0d puts, %0d reads, %0d direct writes, %0d unused selectors.",
               sent, sb.puts, sb.reads, sb.writes, sb.unused);
      $display("Checked %0d results across %0d scrolls, %0d mismatches.",
               sb.checked, sb.scrolls, sb.mismatches);
      if (sb.mismatches == 0) begin
         $display("testbench: PASS");
      end else begin
         $display("testbench: FAIL");
      end
      $finish;
   end

   initial begin : receiver
      int hold_left, served;
      hold_left = 0;
      served = 0;
      forever begin
         @(posedge clock);
         if (!reset && rsp_valid && !rsp_stall)
            sb.check_result(rsp_cell_char, rsp_cell_colour, rsp_cursor_cell, rsp_scrolled);
         if (served < hold_off_requests) begin
            served++;
            hold_left = HOLD_OFF_CYCLES;
         end
         if (hold_left > 0) begin
            hold_left--;
            rsp_stall <= 1'b1;
         end else begin
            rsp_stall <= ($urandom_range(99) < rsp_idle_pct);
         end
      end
   end

   initial begin : watchdog
      #4_000_000;
      $display("testbench: FAIL");
      $finish;
   end

endmodule
